// ----- design/xdzr_pkg.sv -----
`timescale 1ns / 1ps
// shared constants of the xor delta zero run decoder
package xdzr_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 4096;
    localparam int FRAME_BYTES_W       = 13;
    localparam int FRAME_BYTES_RST     = 4096;
    localparam int ACC_W               = 21;
    localparam int GROUP_W             = 7;
    localparam int MAX_GROUPS          = 3;
    localparam int POS_OUT_W           = 12;
    localparam int BYTE_W              = 8;

    localparam logic [BYTE_W-1:0] GROUP_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] MORE_FLAG  = 8'h80;

endpackage

// ----- design/xor_delta_zero_run_decoder_top.sv -----
`timescale 1ns / 1ps
// xor delta zero run decoder: position tracking, snapshot update and result register
// One payload word is accepted per clock while the result side is not stalled; each gives
// one registered result word. The snapshot sits in a single-port-write memory, read on
// accept and written back as the word leaves stage one, with forwarding when a word hits
// the entry being written. After reset the memory is swept to zero, during which no
// payload word is accepted; frame size writes are taken at any time.
module xor_delta_zero_run_decoder_top #(
    parameter int MAX_FRAME_BYTES = xdzr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_raw_frame,
    input  logic        i_last_of_frame,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_write_valid,
    output logic [11:0] o_byte_position,
    output logic [7:0]  o_new_value,
    output logic        o_frame_end,
    output logic        o_overrun
);

    localparam int PW  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int AW  = $clog2(MAX_FRAME_BYTES);
    localparam int AC  = xdzr_pkg::ACC_W;
    localparam int SW  = (PW > AC) ? PW : AC;
    localparam int OW  = xdzr_pkg::POS_OUT_W;
    localparam int BW  = xdzr_pkg::BYTE_W;

    logic [xdzr_pkg::FRAME_BYTES_W-1:0] r_frame_bytes;

    logic [PW-1:0] r_pos, n_pos;
    logic          r_in_count, n_in_count;
    logic [AC-1:0] r_acc, n_acc;
    logic [1:0]    r_shift, n_shift;

    logic          r_s1_valid;
    logic          r_s1_wr;
    logic [AW-1:0] r_s1_addr;
    logic [OW-1:0] r_s1_pos;
    logic [BW-1:0] r_s1_byte;
    logic          r_s1_last;
    logic          r_s1_over;
    logic          r_fwd;
    logic [BW-1:0] r_fwd_data;

    logic          r_o_valid;
    logic          r_o_wr;
    logic [OW-1:0] r_o_pos;
    logic [BW-1:0] r_o_val;
    logic          r_o_last;
    logic          r_o_over;

    logic          n_wr;
    logic          n_over;
    logic          accept;
    logic          s1_adv;
    logic          ram_busy;
    logic [BW-1:0] rd_data;
    logic [BW-1:0] s1_new;
    logic [AW-1:0] rd_addr;

    logic [SW-1:0] size_w, pos_w, room_w, acc_w, fb_w;
    logic          in_range;
    logic [AC-1:0] acc_new;
    logic [1:0]    shift_new;
    logic [4:0]    sh_amt;
    logic          cnt_end;
    logic [PW+OW-1:0] pos_ext;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= xdzr_pkg::FRAME_BYTES_W'(xdzr_pkg::FRAME_BYTES_RST);
        end else if (i_cfg_valid) begin
            r_frame_bytes <= i_cfg_data;
        end
    end

    assign s1_adv  = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready = !ram_busy && (!r_s1_valid || s1_adv);
    assign accept  = i_valid && o_ready;
    assign rd_addr = r_pos[AW-1:0];

    // position and run count control
    always_comb begin
        fb_w      = SW'(r_frame_bytes);
        size_w    = (fb_w > SW'(MAX_FRAME_BYTES)) ? SW'(MAX_FRAME_BYTES) : fb_w;
        pos_w     = SW'(r_pos);
        in_range  = pos_w < size_w;
        room_w    = in_range ? (size_w - pos_w) : '0;
        sh_amt    = 5'(r_shift) * 5'(xdzr_pkg::GROUP_W);
        acc_new   = r_acc | (AC'(i_payload_byte & xdzr_pkg::GROUP_MASK) << sh_amt);
        acc_w     = SW'(acc_new);
        shift_new = r_shift + 2'd1;
        cnt_end   = ((i_payload_byte & xdzr_pkg::MORE_FLAG) == '0)
                    || (shift_new >= 2'(xdzr_pkg::MAX_GROUPS));

        n_pos      = r_pos;
        n_in_count = r_in_count;
        n_acc      = r_acc;
        n_shift    = r_shift;
        n_wr       = 1'b0;
        n_over     = 1'b0;

        if (i_raw_frame || (!r_in_count && i_payload_byte != '0)) begin
            n_in_count = 1'b0;
            n_acc      = '0;
            n_shift    = '0;
            if (in_range) begin
                n_wr  = 1'b1;
                n_pos = r_pos + 1'b1;
            end else begin
                n_over = 1'b1;
            end
        end else if (r_in_count) begin
            n_acc   = acc_new;
            n_shift = shift_new;
            if (cnt_end) begin
                if (acc_w >= room_w) begin
                    n_pos = (size_w > pos_w) ? PW'(size_w) : r_pos;
                end else begin
                    n_pos = PW'(pos_w + acc_w);
                end
                n_in_count = 1'b0;
                n_acc      = '0;
                n_shift    = '0;
            end
        end else begin
            if (!in_range) begin
                n_over = 1'b1;
            end else begin
                n_in_count = 1'b1;
                n_acc      = '0;
                n_shift    = '0;
            end
        end

        if (i_last_of_frame) begin
            n_pos      = '0;
            n_in_count = 1'b0;
            n_acc      = '0;
            n_shift    = '0;
        end
    end

    assign pos_ext = {{OW{1'b0}}, r_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_in_count <= 1'b0;
            r_acc      <= '0;
            r_shift    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos      <= n_pos;
                r_in_count <= n_in_count;
                r_acc      <= n_acc;
                r_shift    <= n_shift;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // stage one payload, forwarding of the write-back in flight
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_wr    <= n_wr;
            r_s1_addr  <= rd_addr;
            r_s1_pos   <= pos_ext[OW-1:0];
            r_s1_byte  <= i_payload_byte;
            r_s1_last  <= i_last_of_frame;
            r_s1_over  <= n_over;
            r_fwd      <= s1_adv && r_s1_wr && (r_s1_addr == rd_addr);
            r_fwd_data <= s1_new;
        end
    end

    assign s1_new = (r_fwd ? r_fwd_data : rd_data) ^ r_s1_byte;

    xdzr_snap_ram #(
        .DEPTH (MAX_FRAME_BYTES),
        .AW    (AW)
    ) u_snap_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_adv && r_s1_wr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (s1_new),
        .o_busy    (ram_busy)
    );

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_wr   <= r_s1_wr;
            r_o_pos  <= r_s1_wr ? r_s1_pos : '0;
            r_o_val  <= r_s1_wr ? s1_new : '0;
            r_o_last <= r_s1_last;
            r_o_over <= r_s1_over;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_write_valid   = r_o_wr;
    assign o_byte_position = r_o_pos;
    assign o_new_value     = r_o_val;
    assign o_frame_end     = r_o_last;
    assign o_overrun       = r_o_over;

endmodule

// ----- design/xdzr_snap_ram.sv -----
`timescale 1ns / 1ps
// snapshot memory with registered read and a clearing sweep after reset
module xdzr_snap_ram #(
    parameter int DEPTH = xdzr_pkg::MAX_FRAME_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [xdzr_pkg::BYTE_W-1:0] o_rd_data,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [xdzr_pkg::BYTE_W-1:0] i_wr_data,
    output logic                      o_busy
);

    logic [xdzr_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [xdzr_pkg::BYTE_W-1:0] r_rd_data;
    logic                        r_clearing;
    logic [AW-1:0]               r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clearing;

endmodule

// ----- design/xdzr_checker.sv -----
`timescale 1ns / 1ps
// port-level checker for the xor delta zero run decoder and its bind
module xdzr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_write_valid,
    input logic [11:0] o_byte_position,
    input logic [7:0]  o_new_value,
    input logic        o_frame_end,
    input logic        o_overrun
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_write_valid)
            && $stable(o_byte_position) && $stable(o_new_value)
            && $stable(o_frame_end) && $stable(o_overrun))
        else $error("result word changed while stalled");

    // no write reports zero position and value
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_valid |-> o_byte_position == '0 && o_new_value == '0)
        else $error("non-write result carries position or value");

    // a write and an overrun never come together
    a_wr_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_write_valid |-> !o_overrun)
        else $error("write flagged as overrun");

    // memory sweep follows reset
    a_rst_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("block active right after reset");

endmodule

bind xor_delta_zero_run_decoder_top xdzr_checker u_xdzr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_write_valid   (o_write_valid),
    .o_byte_position (o_byte_position),
    .o_new_value     (o_new_value),
    .o_frame_end     (o_frame_end),
    .o_overrun       (o_overrun)
);

// ----- tb/sv/xdzr_snapshot_checker.sv -----
`timescale 1ns / 1ps
// checker: watches the decoder channels, predicts each result word and compares it
module xdzr_snapshot_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [xdzr_pkg::FRAME_BYTES_W-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [xdzr_pkg::BYTE_W-1:0]         i_payload_byte,
    input  logic                                i_raw_frame,
    input  logic                                i_last_of_frame,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_write_valid,
    input  logic [xdzr_pkg::POS_OUT_W-1:0]      i_byte_position,
    input  logic [xdzr_pkg::BYTE_W-1:0]         i_new_value,
    input  logic                                i_frame_end,
    input  logic                                i_overrun,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_writes,
    output int                                  o_overruns
);

    import xdzr_pkg::*;

    localparam logic [FRAME_BYTES_W-1:0] FRAME_LIMIT = FRAME_BYTES_W'(MAX_FRAME_BYTES_DEF);

    typedef struct packed {
        logic                 write_valid;
        logic [POS_OUT_W-1:0] byte_position;
        logic [BYTE_W-1:0]    new_value;
        logic                 frame_end;
        logic                 overrun;
    } snap_update_t;

    logic [BYTE_W-1:0]        snapshot [MAX_FRAME_BYTES_DEF];
    logic [FRAME_BYTES_W-1:0] frame_size;
    logic [FRAME_BYTES_W-1:0] cur_pos;
    logic                     counting;
    logic [ACC_W-1:0]         run_len;
    logic [1:0]               group_cnt;

    snap_update_t expected_updates [$];
    int fail_cnt;
    int write_cnt;
    int overrun_cnt;

    function automatic snap_update_t apply_payload_byte(input logic [BYTE_W-1:0] b,
                                                        input logic raw,
                                                        input logic last);
        snap_update_t             u;
        logic [FRAME_BYTES_W-1:0] lim;
        logic [FRAME_BYTES_W-1:0] room;
        logic [ACC_W-1:0]         grp;
        logic                     do_xor;
        u      = '0;
        do_xor = 1'b0;
        lim    = (frame_size > FRAME_LIMIT) ? FRAME_LIMIT : frame_size;
        if (raw) begin
            counting  = 1'b0;
            run_len   = '0;
            group_cnt = '0;
            do_xor    = 1'b1;
        end else if (counting) begin
            grp = '0;
            grp[GROUP_W-1:0] = b[GROUP_W-1:0];
            run_len   = run_len | (grp << (group_cnt * GROUP_W));
            group_cnt = group_cnt + 2'd1;
            if ((b & MORE_FLAG) == '0 || group_cnt >= MAX_GROUPS) begin
                room = (cur_pos < lim) ? lim - cur_pos : '0;
                if (run_len >= room) begin
                    if (lim > cur_pos) cur_pos = lim;
                end else begin
                    cur_pos = cur_pos + run_len[FRAME_BYTES_W-1:0];
                end
                counting  = 1'b0;
                run_len   = '0;
                group_cnt = '0;
            end
        end else if (b == '0) begin
            if (cur_pos >= lim) begin
                u.overrun = 1'b1;
            end else begin
                counting  = 1'b1;
                run_len   = '0;
                group_cnt = '0;
            end
        end else begin
            do_xor = 1'b1;
        end

        if (do_xor) begin
            if (cur_pos >= lim) begin
                u.overrun = 1'b1;
            end else begin
                snapshot[cur_pos[POS_OUT_W-1:0]] = snapshot[cur_pos[POS_OUT_W-1:0]] ^ b;
                u.write_valid   = 1'b1;
                u.byte_position = cur_pos[POS_OUT_W-1:0];
                u.new_value     = snapshot[cur_pos[POS_OUT_W-1:0]];
                cur_pos         = cur_pos + 1'b1;
            end
        end

        u.frame_end = last;
        if (last) begin
            cur_pos   = '0;
            counting  = 1'b0;
            run_len   = '0;
            group_cnt = '0;
        end
        return u;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        snap_update_t want;
        snap_update_t got;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_FRAME_BYTES_DEF; i++) snapshot[i] = '0;
            frame_size  = FRAME_BYTES_W'(FRAME_BYTES_RST);
            cur_pos     = '0;
            counting    = 1'b0;
            run_len     = '0;
            group_cnt   = '0;
            expected_updates.delete();
            fail_cnt    = 0;
            write_cnt   = 0;
            overrun_cnt = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) frame_size = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                expected_updates.push_back(
                    apply_payload_byte(i_payload_byte, i_raw_frame, i_last_of_frame));
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_write_valid, i_byte_position, i_new_value, i_frame_end, i_overrun};
                if (expected_updates.size() == 0) begin
                    $error("result word with nothing expected: position %0d value 0x%0h",
                           i_byte_position, i_new_value);
                    fail_cnt++;
                end else begin
                    want = expected_updates.pop_front();
                    check_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
                    check_field("byte_position", 32'(want.byte_position),
                                32'(got.byte_position));
                    check_field("new_value", 32'(want.new_value), 32'(got.new_value));
                    check_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
                    check_field("overrun", 32'(want.overrun), 32'(got.overrun));
                    if (want.write_valid) write_cnt++;
                    if (want.overrun) overrun_cnt++;
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_updates.size();
        o_writes     <= write_cnt;
        o_overruns   <= overrun_cnt;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus and verdict for the xor delta zero run decoder
module tb_top;

    import xdzr_pkg::*;

    localparam int QUIET_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int PHASE_WORDS    = 112;

    localparam logic RAW   = 1'b1;
    localparam logic CODED = 1'b0;
    localparam logic LAST  = 1'b1;
    localparam logic MID   = 1'b0;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              raw;
        logic              last;
    } payload_word_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [FRAME_BYTES_W-1:0] cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic [BYTE_W-1:0]        in_byte   = '0;
    logic                     in_raw    = 1'b0;
    logic                     in_last   = 1'b0;
    logic                     out_ready = 1'b0;

    logic                     cfg_ready;
    logic                     in_ready;
    logic                     out_valid;
    logic                     wr_valid;
    logic [POS_OUT_W-1:0]     wr_pos;
    logic [BYTE_W-1:0]        wr_value;
    logic                     frame_end;
    logic                     overrun;

    int fail_count;
    int pending;
    int writes_seen;
    int overruns_seen;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic squeeze_req  = 1'b0;
    logic squeeze_done = 1'b0;
    int squeeze_left   = 0;
    int quiet_cycles   = 0;

    int words_sent    = 0;
    int frames_closed = 0;
    int sizes_written = 0;

    payload_word_t frame_q [$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    xor_delta_zero_run_decoder_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_payload_byte  (in_byte),
        .i_raw_frame     (in_raw),
        .i_last_of_frame (in_last),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_write_valid   (wr_valid),
        .o_byte_position (wr_pos),
        .o_new_value     (wr_value),
        .o_frame_end     (frame_end),
        .o_overrun       (overrun)
    );

    xdzr_snapshot_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_payload_byte  (in_byte),
        .i_raw_frame     (in_raw),
        .i_last_of_frame (in_last),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_write_valid   (wr_valid),
        .i_byte_position (wr_pos),
        .i_new_value     (wr_value),
        .i_frame_end     (frame_end),
        .i_overrun       (overrun),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_writes        (writes_seen),
        .o_overruns      (overruns_seen)
    );

    // result side: random stalls plus one long hold-off on request
    always @(posedge clk) begin
        if (squeeze_left > 0) begin
            squeeze_left <= squeeze_left - 1;
            out_ready    <= 1'b0;
        end else if (squeeze_req && !squeeze_done) begin
            squeeze_done <= 1'b1;
            squeeze_left <= SQUEEZE_CYCLES;
            out_ready    <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input payload_word_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= w.b;
        in_raw   <= w.raw;
        in_last  <= w.last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
        if (w.last) frames_closed++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_size(input logic [FRAME_BYTES_W-1:0] size);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sizes_written++;
    endtask

    // one frame of random content, mostly well formed
    task automatic build_frame();
        logic              raw_mode;
        int                tokens;
        int                sel;
        int                groups;
        logic [BYTE_W-1:0] g;
        raw_mode = ($urandom_range(3) == 0);
        tokens   = $urandom_range(1, 12);
        for (int t = 0; t < tokens; t++) begin
            sel = $urandom_range(99);
            if (raw_mode) begin
                frame_q.push_back({8'($urandom_range(255)), RAW, MID});
            end else if (sel < 55) begin
                frame_q.push_back({8'($urandom_range(1, 255)), CODED, MID});
            end else if (sel < 90) begin
                frame_q.push_back({8'h00, CODED, MID});
                sel    = $urandom_range(9);
                groups = (sel < 6) ? 1 : (sel < 9) ? 2 : 3;
                for (int k = 0; k < groups; k++) begin
                    g = (groups == 1) ? 8'($urandom_range(0, 12)) : 8'($urandom_range(0, 127));
                    if (k < groups - 1) g[7] = 1'b1;
                    else if (k == 2) g[7] = 1'($urandom_range(1));
                    frame_q.push_back({g, CODED, MID});
                end
            end else if (sel < 95) begin
                // run start cut short by whatever comes next
                frame_q.push_back({8'h00, CODED, MID});
            end else begin
                frame_q.push_back({8'($urandom_range(255)), 1'($urandom_range(1)), MID});
            end
        end
        if ($urandom_range(19) != 0) frame_q[frame_q.size() - 1].last = LAST;
    endtask

    task automatic run_phase(input logic [FRAME_BYTES_W-1:0] size, input int send_pct,
                             input int stall_pct, input logic squeeze);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= stall_pct;
        write_frame_size(size);
        squeeze_req <= squeeze;
        for (int n = 0; n < PHASE_WORDS; n++) begin
            if (frame_q.size() == 0) build_frame();
            send_word(frame_q.pop_front());
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        write_frame_size(13'd4096);
        // coded frame: literals, runs of one and two groups, zero run, raw drop of
        // a pending count, three group run that saturates, then overruns
        frame_q.push_back({8'h5A, CODED, MID});
        frame_q.push_back({8'h00, CODED, MID});
        frame_q.push_back({8'h03, CODED, MID});
        frame_q.push_back({8'h00, CODED, MID});
        frame_q.push_back({8'h00, CODED, MID});
        frame_q.push_back({8'h00, CODED, MID});
        frame_q.push_back({8'h85, CODED, MID});
        frame_q.push_back({8'h01, CODED, MID});
        frame_q.push_back({8'h7F, CODED, MID});
        frame_q.push_back({8'h00, CODED, MID});
        frame_q.push_back({8'h33, RAW,   MID});
        frame_q.push_back({8'h00, CODED, MID});
        frame_q.push_back({8'hFF, CODED, MID});
        frame_q.push_back({8'hFF, CODED, MID});
        frame_q.push_back({8'hFF, CODED, MID});
        frame_q.push_back({8'hA5, CODED, MID});
        frame_q.push_back({8'h00, CODED, MID});
        frame_q.push_back({8'h01, RAW,   LAST});
        // count left pending at frame end
        frame_q.push_back({8'h00, CODED, MID});
        frame_q.push_back({8'h81, CODED, LAST});
        // raw frame with a zero byte
        frame_q.push_back({8'h00, RAW,   MID});
        frame_q.push_back({8'hFF, RAW,   MID});
        frame_q.push_back({8'h80, RAW,   LAST});
        // frame left open; the next phase lowers the size below its position
        frame_q.push_back({8'h11, RAW,   MID});
        frame_q.push_back({8'h22, RAW,   MID});
        frame_q.push_back({8'h44, RAW,   MID});
        frame_q.push_back({8'h88, RAW,   MID});
        while (frame_q.size() != 0) send_word(frame_q.pop_front());

        run_phase(13'd2,    0,  0,  1'b0);
        run_phase(13'd16,   68, 0,  1'b0);
        run_phase(13'd0,    0,  68, 1'b0);
        run_phase(13'd1,    8,  8,  1'b0);
        run_phase(13'd8191, 0,  0,  1'b1);
        run_phase(13'd3,    68, 0,  1'b0);
        run_phase(13'd200,  0,  68, 1'b0);
        run_phase(13'd4096, 8,  8,  1'b0);
        run_phase(13'd37,   0,  0,  1'b0);
        run_phase(13'd5,    0,  68, 1'b0);

        wait_drained();
        $display("sent %0d payload words (%0d frames closed) under %0d frame size settings",
                 words_sent, frames_closed, sizes_written);
        $display("results checked: %0d snapshot writes, %0d overruns", writes_seen,
                 overruns_seen);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
